FILE: design/assert_macros.svh
// Assertion macros for the checker file of the day difference block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off while reset is high.
`define GDD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gdd check failed: same-cycle rule");

// Next-cycle implication, sampled on the rising clock, off while reset is high.
`define GDD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gdd check failed: next-cycle rule");

`endif

FILE: design/gdd_pkg.sv
// Types, widths, constants and calendar helpers for the Gregorian day difference block.
`default_nettype none

package gdd_pkg;

   // Field widths of the input and result beats.
   localparam int DAY_W     = 5;
   localparam int MONTH_W   = 4;
   localparam int YEAR_W    = 14;
   localparam int COUNT_W   = 23;
   localparam int WEEKDAY_W = 3;

   // Internal widths.
   localparam int CENT_W  = 8;   // ceil(year / 100)
   localparam int SUM_W   = 14;  // leap days before the year plus day of year
   localparam int WSUM_W  = 15;  // weekday residue operand
   localparam int DOY_W   = 9;   // month start offsets
   localparam int MUL_A_W = 15;
   localparam int MUL_B_W = 18;
   localparam int MUL_W   = MUL_A_W + MUL_B_W;
   localparam int Q7_W    = 13;

   // Years above this limit are taken as the limit.
   localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;

   // ceil(y / 100) = ((y + 99) * RECIP_100) >> SHIFT_100 for all years in range.
   localparam logic [MUL_A_W-1:0] CENT_BIAS = 15'd99;
   localparam logic [MUL_B_W-1:0] RECIP_100 = 18'd20972;
   localparam int                 SHIFT_100 = 21;

   // floor(v / 7) = (v * RECIP_7) >> SHIFT_7 for every residue operand in range.
   localparam logic [MUL_B_W-1:0] RECIP_7 = 18'd149797;
   localparam int                 SHIFT_7 = 20;

   localparam logic [MUL_B_W-1:0] DAYS_PER_YEAR = 18'd365;

   // Since 365 is 1 modulo 7, the ordinal of a date is congruent to
   // year + leap days + day of year. Sunday 1980-01-06 is congruent to 2,
   // so adding 5 lines up the residue with Sunday as zero.
   localparam logic [WSUM_W-1:0] WEEK_BIAS = 15'd5;

   typedef logic [YEAR_W-1:0]  year_type;
   typedef logic [CENT_W-1:0]  cent_type;
   typedef logic [SUM_W-1:0]   sum_type;
   typedef logic [COUNT_W-1:0] ordinal_type;

   // Days in the months before the given one in a common year.
   function automatic logic [DOY_W-1:0] month_start(input logic [MONTH_W-1:0] month);
      logic [DOY_W-1:0] days;
      case (month)
         4'd2:    days = 9'd31;
         4'd3:    days = 9'd59;
         4'd4:    days = 9'd90;
         4'd5:    days = 9'd120;
         4'd6:    days = 9'd151;
         4'd7:    days = 9'd181;
         4'd8:    days = 9'd212;
         4'd9:    days = 9'd243;
         4'd10:   days = 9'd273;
         4'd11:   days = 9'd304;
         4'd12:   days = 9'd334;
         default: days = 9'd0;
      endcase
      return days;
   endfunction

   function automatic year_type clamp_year(input year_type year);
      return (year > YEAR_MAX) ? YEAR_MAX : year;
   endfunction

endpackage

`default_nettype wire

FILE: design/gdd_day_terms.sv
// Leap days before a year plus the day of year, given the year's rounded-up century count.
`default_nettype none

module gdd_day_terms (
   input  logic [gdd_pkg::YEAR_W-1:0]  year,
   input  logic [gdd_pkg::CENT_W-1:0]  cent,
   input  logic [gdd_pkg::MONTH_W-1:0] month,
   input  logic [gdd_pkg::DAY_W-1:0]   day,
   output logic [gdd_pkg::SUM_W-1:0]   day_sum
);
   import gdd_pkg::*;

   logic [YEAR_W:0] year_plus3;
   logic [CENT_W:0] cent_plus3;
   logic [YEAR_W:0] cent_x100;
   logic [SUM_W-1:0] leaps;
   logic [SUM_W-1:0] doy;
   logic on_century;
   logic is_leap;
   logic after_feb;

   always_comb begin
      year_plus3 = {1'b0, year} + (YEAR_W+1)'(3);
      cent_plus3 = {1'b0, cent} + (CENT_W+1)'(3);
      // ceil(y/4) - ceil(y/100) + ceil(y/400); the last is ceil(ceil(y/100)/4).
      leaps = SUM_W'(year_plus3 >> 2) - SUM_W'(cent) + SUM_W'(cent_plus3 >> 2);

      // The year is a century year exactly when 100 * ceil(y/100) equals it.
      cent_x100 = ((YEAR_W+1)'(cent) << 6) + ((YEAR_W+1)'(cent) << 5)
                + ((YEAR_W+1)'(cent) << 2);
      on_century = (cent_x100 == {1'b0, year});
      is_leap    = (year[1:0] == 2'b00) && (!on_century || cent[1:0] == 2'b00);
      after_feb  = month inside {[4'd3:4'd12]};

      doy = SUM_W'(month_start(month)) + SUM_W'(day) + SUM_W'(after_feb && is_leap);
      day_sum = leaps + doy;
   end

endmodule

`default_nettype wire

FILE: design/gregorian_day_difference.sv
// Top level of the Gregorian day difference block: sequencer, shared multiplier and result register.
`default_nettype none

// Each input beat carries a start date and an end date; the result beat gives the signed
// number of days from start to end, whether the end comes before the start (year, then
// month, then day), whether the dates are identical, and the weekday of the end date with
// Sunday as zero. Years above 9999 are treated as 9999, and dates are not checked, so a
// day or month out of range simply shifts the count. The block takes no new beat until
// it is through with the current item. A single registered multiplier is shared by the
// steps that multiply, once per date for the century count, once per date for 365 times
// the year, and once for the weekday residue, under an eleven-step sequencer. The input
// stall is high while the sequencer works. The result sits in an output register, so a
// new item can be accepted and worked on while the previous result is still stalled;
// the sequencer only waits at its last step if that register is full and stalled.
// There are no configuration registers and no state that carries from item to item.

module gregorian_day_difference (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [gdd_pkg::DAY_W-1:0]          req_start_day,
   input  logic [gdd_pkg::MONTH_W-1:0]        req_start_month,
   input  logic [gdd_pkg::YEAR_W-1:0]         req_start_year,
   input  logic [gdd_pkg::DAY_W-1:0]          req_end_day,
   input  logic [gdd_pkg::MONTH_W-1:0]        req_end_month,
   input  logic [gdd_pkg::YEAR_W-1:0]         req_end_year,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [gdd_pkg::COUNT_W-1:0] rsp_day_count,
   output logic                               rsp_end_is_before,
   output logic                               rsp_dates_equal,
   output logic [gdd_pkg::WEEKDAY_W-1:0]      rsp_end_weekday
);
   import gdd_pkg::*;

   // Sequencer steps. The first four run once for the end date and once for the start.
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_DIV   = 3'd1;  // multiply (year + 99) by the 1/100 reciprocal
   localparam logic [2:0] ST_CENT  = 3'd2;  // take the century count, multiply year by 365
   localparam logic [2:0] ST_TERMS = 3'd3;  // leap days plus day of year
   localparam logic [2:0] ST_ORD   = 3'd4;  // ordinal = 365 * year + terms
   localparam logic [2:0] ST_WDIV  = 3'd5;  // multiply the weekday operand by the 1/7 reciprocal
   localparam logic [2:0] ST_WREM  = 3'd6;  // remainder modulo 7
   localparam logic [2:0] ST_FIN   = 3'd7;  // load the result register

   localparam logic SEL_END   = 1'b0;
   localparam logic SEL_START = 1'b1;

   // Control registers.
   logic [2:0] state_ff, state_in;
   logic       sel_ff, sel_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // Working registers.
   logic [DAY_W-1:0]   start_day_ff, start_day_in;
   logic [MONTH_W-1:0] start_month_ff, start_month_in;
   year_type           start_year_ff, start_year_in;
   logic [DAY_W-1:0]   end_day_ff, end_day_in;
   logic [MONTH_W-1:0] end_month_ff, end_month_in;
   year_type           end_year_ff, end_year_in;
   logic [MUL_W-1:0]   mul_ff, mul_in;
   cent_type           cent_ff, cent_in;
   sum_type            sum_ff, sum_in;
   ordinal_type        end_ord_ff, end_ord_in;
   ordinal_type        start_ord_ff, start_ord_in;
   logic [WSUM_W-1:0]  wsum_ff, wsum_in;
   logic [WEEKDAY_W-1:0] wday_ff, wday_in;

   // Result register.
   logic signed [COUNT_W-1:0] rsp_day_count_ff, rsp_day_count_in;
   logic                      rsp_end_is_before_ff, rsp_end_is_before_in;
   logic                      rsp_dates_equal_ff, rsp_dates_equal_in;
   logic [WEEKDAY_W-1:0]      rsp_end_weekday_ff, rsp_end_weekday_in;

   // Combinational signals.
   logic               accept;
   logic               load_rsp;
   year_type           cur_year;
   logic [MONTH_W-1:0] cur_month;
   logic [DAY_W-1:0]   cur_day;
   sum_type            cur_sum;
   ordinal_type        cur_ord;
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [Q7_W-1:0]    quot7;
   logic [WSUM_W-1:0]  rem7;

   gdd_day_terms u_terms (
      .year    (cur_year),
      .cent    (cent_ff),
      .month   (cur_month),
      .day     (cur_day),
      .day_sum (cur_sum)
   );

   always_comb begin
      accept   = req_valid && (state_ff == ST_IDLE);
      load_rsp = (state_ff == ST_FIN) && (!rsp_valid_ff || !rsp_stall);

      cur_year  = (sel_ff == SEL_START) ? start_year_ff  : end_year_ff;
      cur_month = (sel_ff == SEL_START) ? start_month_ff : end_month_ff;
      cur_day   = (sel_ff == SEL_START) ? start_day_ff   : end_day_ff;
      cur_ord   = mul_ff[COUNT_W-1:0] + COUNT_W'(sum_ff);

      // Operand selection for the shared multiplier.
      case (state_ff)
         ST_DIV: begin
            mul_a = MUL_A_W'(cur_year) + CENT_BIAS;
            mul_b = RECIP_100;
         end
         ST_CENT: begin
            mul_a = MUL_A_W'(cur_year);
            mul_b = DAYS_PER_YEAR;
         end
         ST_WDIV: begin
            mul_a = wsum_ff;
            mul_b = RECIP_7;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase

      quot7 = mul_ff[SHIFT_7 +: Q7_W];
      rem7  = wsum_ff - WSUM_W'({quot7, 3'b000} - {3'b000, quot7});

      // Defaults hold every register.
      state_in       = state_ff;
      sel_in         = sel_ff;
      start_day_in   = start_day_ff;
      start_month_in = start_month_ff;
      start_year_in  = start_year_ff;
      end_day_in     = end_day_ff;
      end_month_in   = end_month_ff;
      end_year_in    = end_year_ff;
      mul_in         = mul_ff;
      cent_in        = cent_ff;
      sum_in         = sum_ff;
      end_ord_in     = end_ord_ff;
      start_ord_in   = start_ord_ff;
      wsum_in        = wsum_ff;
      wday_in        = wday_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               start_day_in   = req_start_day;
               start_month_in = req_start_month;
               start_year_in  = clamp_year(req_start_year);
               end_day_in     = req_end_day;
               end_month_in   = req_end_month;
               end_year_in    = clamp_year(req_end_year);
               sel_in         = SEL_END;
               state_in       = ST_DIV;
            end
         end
         ST_DIV: begin
            mul_in   = MUL_W'(mul_a) * MUL_W'(mul_b);
            state_in = ST_CENT;
         end
         ST_CENT: begin
            cent_in  = mul_ff[SHIFT_100 +: CENT_W];
            mul_in   = MUL_W'(mul_a) * MUL_W'(mul_b);
            state_in = ST_TERMS;
         end
         ST_TERMS: begin
            sum_in   = cur_sum;
            state_in = ST_ORD;
         end
         ST_ORD: begin
            if (sel_ff == SEL_END) begin
               end_ord_in = cur_ord;
               wsum_in    = WSUM_W'(cur_year) + WSUM_W'(sum_ff) + WEEK_BIAS;
               sel_in     = SEL_START;
               state_in   = ST_DIV;
            end else begin
               start_ord_in = cur_ord;
               state_in     = ST_WDIV;
            end
         end
         ST_WDIV: begin
            mul_in   = MUL_W'(mul_a) * MUL_W'(mul_b);
            state_in = ST_WREM;
         end
         ST_WREM: begin
            wday_in  = rem7[WEEKDAY_W-1:0];
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // The result register holds until taken; a full register that is taken in the same
      // cycle as the new result arrives is simply overwritten.
      rsp_valid_in         = load_rsp || (rsp_valid_ff && rsp_stall);
      rsp_day_count_in     = rsp_day_count_ff;
      rsp_end_is_before_in = rsp_end_is_before_ff;
      rsp_dates_equal_in   = rsp_dates_equal_ff;
      rsp_end_weekday_in   = rsp_end_weekday_ff;
      if (load_rsp) begin
         rsp_day_count_in     = end_ord_ff - start_ord_ff;
         rsp_end_is_before_in = {end_year_ff, end_month_ff, end_day_ff}
                              < {start_year_ff, start_month_ff, start_day_ff};
         rsp_dates_equal_in   = {end_year_ff, end_month_ff, end_day_ff}
                             == {start_year_ff, start_month_ff, start_day_ff};
         rsp_end_weekday_in   = wday_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sel_ff       <= SEL_END;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      start_day_ff         <= start_day_in;
      start_month_ff       <= start_month_in;
      start_year_ff        <= start_year_in;
      end_day_ff           <= end_day_in;
      end_month_ff         <= end_month_in;
      end_year_ff          <= end_year_in;
      mul_ff               <= mul_in;
      cent_ff              <= cent_in;
      sum_ff               <= sum_in;
      end_ord_ff           <= end_ord_in;
      start_ord_ff         <= start_ord_in;
      wsum_ff              <= wsum_in;
      wday_ff              <= wday_in;
      rsp_day_count_ff     <= rsp_day_count_in;
      rsp_end_is_before_ff <= rsp_end_is_before_in;
      rsp_dates_equal_ff   <= rsp_dates_equal_in;
      rsp_end_weekday_ff   <= rsp_end_weekday_in;
   end

   // The input side stalls whenever the sequencer is away from its idle step.
   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_day_count     = rsp_day_count_ff;
   assign rsp_end_is_before = rsp_end_is_before_ff;
   assign rsp_dates_equal   = rsp_dates_equal_ff;
   assign rsp_end_weekday   = rsp_end_weekday_ff;

endmodule

`default_nettype wire

FILE: design/gdd_checker.sv
// Port-level checker for the Gregorian day difference block, with its bind.
`default_nettype none
`include "assert_macros.svh"

module gdd_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic [gdd_pkg::DAY_W-1:0]          req_start_day,
   input  logic [gdd_pkg::MONTH_W-1:0]        req_start_month,
   input  logic [gdd_pkg::YEAR_W-1:0]         req_start_year,
   input  logic [gdd_pkg::DAY_W-1:0]          req_end_day,
   input  logic [gdd_pkg::MONTH_W-1:0]        req_end_month,
   input  logic [gdd_pkg::YEAR_W-1:0]         req_end_year,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic signed [gdd_pkg::COUNT_W-1:0] rsp_day_count,
   input  logic                               rsp_end_is_before,
   input  logic                               rsp_dates_equal,
   input  logic [gdd_pkg::WEEKDAY_W-1:0]      rsp_end_weekday
);
   import gdd_pkg::*;

   // A stalled result beat stays and keeps its payload.
   `GDD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_day_count) && $stable(rsp_end_is_before) && $stable(rsp_dates_equal) && $stable(rsp_end_weekday))

   // Identical dates give a zero count and are never reported as reversed.
   `GDD_ASSERT_NOW(a_equal_zero, clock, reset, rsp_valid && rsp_dates_equal, rsp_day_count == '0 && !rsp_end_is_before)

   // The block works on one item at a time: it stalls right after taking a beat.
   `GDD_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)

   // The weekday is a residue modulo 7.
   `GDD_ASSERT_NOW(a_weekday_range, clock, reset, rsp_valid, rsp_end_weekday != 3'd7)

endmodule

bind gregorian_day_difference gdd_checker u_gdd_checker (.*);

`default_nettype wire
